@@ sv/brb_pkg.sv @@
// shared types and constants for the byte ring buffer
package brb_pkg;

    localparam int DATA_W  = 8;
    localparam int FIELD_W = 12;
    localparam int SHIFT_W = 4;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_DISCARD = 2'd1,
        OP_READ    = 2'd2,
        OP_NOP     = 2'd3
    } t_opcode;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MOD  = 5'b00010,
        S_READ = 5'b00100,
        S_EXEC = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    typedef struct packed {
        logic               accept;
        logic               mod_step;
        logic [SHIFT_W-1:0] shift;
        logic               mem_read;
        logic               exec;
        logic               load_out;
    } t_cmd;

endpackage

@@ sv/brb_if.sv @@
// valid/ready channel interfaces for operations in and results out
interface brb_in_if;
    logic                          valid;
    logic                          ready;
    brb_pkg::t_opcode              opcode;
    logic [brb_pkg::DATA_W-1:0]    data_byte;
    logic [brb_pkg::FIELD_W-1:0]   count;
    logic [brb_pkg::FIELD_W-1:0]   position;

    modport source (output valid, opcode, data_byte, count, position, input ready);
    modport sink   (input valid, opcode, data_byte, count, position, output ready);
endinterface

interface brb_out_if;
    logic                          valid;
    logic                          ready;
    logic [brb_pkg::DATA_W-1:0]    read_byte;
    logic                          refused;
    logic [brb_pkg::FIELD_W-1:0]   stored_len;
    logic [brb_pkg::FIELD_W-1:0]   free_len;
    logic [brb_pkg::FIELD_W-1:0]   contig_free;
    logic [brb_pkg::FIELD_W-1:0]   contig_data;
    logic [brb_pkg::FIELD_W-1:0]   head_index;
    logic [brb_pkg::FIELD_W-1:0]   rear_index;

    modport source (output valid, read_byte, refused, stored_len, free_len, contig_free,
                    contig_data, head_index, rear_index, input ready);
    modport sink   (input valid, read_byte, refused, stored_len, free_len, contig_free,
                    contig_data, head_index, rear_index, output ready);
endinterface

@@ sv/brb_ctrl.sv @@
// operation sequencer: accept, position reduction, memory read, execute, result load
module brb_ctrl #(
    parameter int MOD_STEPS = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  brb_pkg::t_opcode  i_opcode,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output brb_pkg::t_cmd     o_cmd
);
    import brb_pkg::*;

    t_state             r_state, n_state;
    logic [SHIFT_W-1:0] r_step, n_step;
    logic               r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.shift = r_step;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_opcode == OP_READ) begin
                        if (MOD_STEPS > 0) begin
                            n_state = S_MOD;
                            n_step  = SHIFT_W'(MOD_STEPS - 1);
                        end else begin
                            n_state = S_READ;
                        end
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_MOD: begin
                // one conditional subtract of a shifted depth per cycle
                o_cmd.mod_step = 1'b1;
                if (r_step == '0) begin
                    n_state = S_READ;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_READ: begin
                o_cmd.mem_read = 1'b1;
                n_state        = S_DONE;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken result");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second transfer taken while an operation is in progress");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_out_valid) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished operation did not reach the output register");

endmodule

@@ sv/brb_dp.sv @@
// pointers, byte store, position reduction and status arithmetic
module brb_dp #(
    parameter int DEPTH = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  brb_pkg::t_cmd                 i_cmd,
    input  brb_pkg::t_opcode              i_opcode,
    input  logic [brb_pkg::DATA_W-1:0]    i_data_byte,
    input  logic [brb_pkg::FIELD_W-1:0]   i_count,
    input  logic [brb_pkg::FIELD_W-1:0]   i_position,
    output logic [brb_pkg::DATA_W-1:0]    o_read_byte,
    output logic                          o_refused,
    output logic [brb_pkg::FIELD_W-1:0]   o_stored_len,
    output logic [brb_pkg::FIELD_W-1:0]   o_free_len,
    output logic [brb_pkg::FIELD_W-1:0]   o_contig_free,
    output logic [brb_pkg::FIELD_W-1:0]   o_contig_data,
    output logic [brb_pkg::FIELD_W-1:0]   o_head_index,
    output logic [brb_pkg::FIELD_W-1:0]   o_rear_index
);
    import brb_pkg::*;

    localparam int AW   = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int SW   = AW + 1;
    localparam int RW   = (AW > FIELD_W) ? AW : FIELD_W;
    localparam int MW   = (CW > FIELD_W) ? CW : FIELD_W;
    localparam int MODW = RW + FIELD_W;

    logic [DATA_W-1:0] mem [DEPTH];

    logic [AW-1:0]     r_rd, r_wr;
    t_opcode           r_op;
    logic [DATA_W-1:0] r_data;
    logic [CW-1:0]     r_cnt;
    logic [RW-1:0]     r_rem;
    logic              r_refused;
    logic [DATA_W-1:0] r_rdata;

    logic [DATA_W-1:0]  r_o_read_byte;
    logic               r_o_refused;
    logic [FIELD_W-1:0] r_o_stored, r_o_free, r_o_cfree, r_o_cdata, r_o_head, r_o_rear;

    logic [CW-1:0]   s_stored, s_free, s_cfree, s_cdata, s_clamp;
    logic [AW-1:0]   s_wr_inc, s_head_next;
    logic            s_full, s_push_ok;
    logic [SW-1:0]   s_head_sum;
    logic [MODW-1:0] s_mod_div, s_rem_ext;

    // occupancy figures from the current pointers
    always_comb begin
        if (r_wr >= r_rd) begin
            s_stored = CW'(r_wr) - CW'(r_rd);
        end else begin
            s_stored = CW'(r_wr) + CW'(DEPTH) - CW'(r_rd);
        end
        s_free = CW'(DEPTH - 1) - s_stored;
        if (r_rd <= r_wr) begin
            s_cfree = CW'(DEPTH) - CW'(r_wr) - CW'(r_rd == '0);
        end else begin
            s_cfree = CW'(r_rd) - CW'(r_wr) - CW'(1);
        end
        if (r_wr < r_rd) begin
            s_cdata = CW'(DEPTH) - CW'(r_rd);
        end else begin
            s_cdata = CW'(r_wr) - CW'(r_rd);
        end
    end

    assign s_wr_inc  = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign s_full    = (s_wr_inc == r_rd);
    assign s_push_ok = i_cmd.exec && (r_op == OP_PUSH) && !s_full;

    // discard is clamped at transfer time, so the head never passes the rear
    assign s_clamp     = (MW'(i_count) > MW'(s_stored)) ? s_stored : CW'(i_count);
    assign s_head_sum  = SW'(r_rd) + SW'(r_cnt);
    assign s_head_next = (s_head_sum >= SW'(DEPTH)) ? AW'(s_head_sum - SW'(DEPTH))
                                                    : AW'(s_head_sum);

    assign s_mod_div = MODW'(DEPTH) << i_cmd.shift;
    assign s_rem_ext = MODW'(r_rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0;
            r_wr <= '0;
        end else begin
            if (s_push_ok) begin
                r_wr <= s_wr_inc;
            end
            if (i_cmd.exec && r_op == OP_DISCARD) begin
                r_rd <= s_head_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op      <= i_opcode;
            r_data    <= i_data_byte;
            r_cnt     <= s_clamp;
            r_rem     <= RW'(i_position);
            r_refused <= 1'b0;
        end
        if (i_cmd.mod_step && s_rem_ext >= s_mod_div) begin
            r_rem <= RW'(s_rem_ext - s_mod_div);
        end
        if (i_cmd.exec && r_op == OP_PUSH && s_full) begin
            r_refused <= 1'b1;
        end
        if (i_cmd.load_out) begin
            r_o_read_byte <= (r_op == OP_READ) ? r_rdata : '0;
            r_o_refused   <= r_refused;
            r_o_stored    <= FIELD_W'(s_stored);
            r_o_free      <= FIELD_W'(s_free);
            r_o_cfree     <= FIELD_W'(s_cfree);
            r_o_cdata     <= FIELD_W'(s_cdata);
            r_o_head      <= FIELD_W'(r_rd);
            r_o_rear      <= FIELD_W'(r_wr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_push_ok) begin
            mem[r_wr] <= r_data;
        end
        if (i_cmd.mem_read) begin
            r_rdata <= mem[r_rem[AW-1:0]];
        end
    end

    assign o_read_byte   = r_o_read_byte;
    assign o_refused     = r_o_refused;
    assign o_stored_len  = r_o_stored;
    assign o_free_len    = r_o_free;
    assign o_contig_free = r_o_cfree;
    assign o_contig_data = r_o_cdata;
    assign o_head_index  = r_o_head;
    assign o_rear_index  = r_o_rear;

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd <= AW'(DEPTH - 1)) && (r_wr <= AW'(DEPTH - 1)))
        else $error("pointer beyond the store");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_op == OP_PUSH && s_full) |=> ($stable(r_wr) && r_refused))
        else $error("push into a full buffer was not refused");

    a_discard_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_op == OP_DISCARD) |=> (s_stored == $past(s_stored) - $past(r_cnt)))
        else $error("discard removed the wrong number of bytes");

endmodule

@@ sv/byte_ring_buffer.sv @@
// byte ring buffer: one operation at a time, result held in an output register
// sequence: push, discard and no-op results pass through execute and done after the input transfer;
//   a read first reduces the position over the bits of (4095 / DEPTH), then reads the byte store
// the sequencer takes a new operation only once the last result is loaded into the output register;
//   a result left untaken holds the sequencer in its last state until it is taken
// reset: synchronous active-low, empties the buffer (both pointers to zero)
module byte_ring_buffer #(
    parameter int DEPTH = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    brb_in_if.sink    i_in,
    brb_out_if.source o_out
);
    import brb_pkg::*;

    localparam int MOD_STEPS = $clog2((2 ** FIELD_W - 1) / DEPTH + 1);

    t_cmd s_cmd;
    logic s_in_ready;
    logic s_out_valid;

    brb_ctrl #(
        .MOD_STEPS (MOD_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_opcode    (i_in.opcode),
        .o_in_ready  (s_in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (s_out_valid),
        .o_cmd       (s_cmd)
    );

    brb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (s_cmd),
        .i_opcode      (i_in.opcode),
        .i_data_byte   (i_in.data_byte),
        .i_count       (i_in.count),
        .i_position    (i_in.position),
        .o_read_byte   (o_out.read_byte),
        .o_refused     (o_out.refused),
        .o_stored_len  (o_out.stored_len),
        .o_free_len    (o_out.free_len),
        .o_contig_free (o_out.contig_free),
        .o_contig_data (o_out.contig_data),
        .o_head_index  (o_out.head_index),
        .o_rear_index  (o_out.rear_index)
    );

    assign i_in.ready  = s_in_ready;
    assign o_out.valid = s_out_valid;

endmodule

@@ verif/byte_ring_buffer_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the byte ring buffer against a shadow ring and status queue
module byte_ring_buffer_tb;
    import brb_pkg::*;

    localparam int RING_DEPTH   = 4096;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_OPS    = 650;

    typedef struct packed {
        logic [DATA_W-1:0]  read_byte;
        logic               refused;
        logic [FIELD_W-1:0] stored_len;
        logic [FIELD_W-1:0] free_len;
        logic [FIELD_W-1:0] contig_free;
        logic [FIELD_W-1:0] contig_data;
        logic [FIELD_W-1:0] head_index;
        logic [FIELD_W-1:0] rear_index;
    } t_ring_status;

    logic i_clk;
    logic i_rst_n;

    brb_in_if  in_ch ();
    brb_out_if out_ch ();

    byte_ring_buffer #(
        .DEPTH (RING_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // shadow copy of the ring
    logic [DATA_W-1:0]  shadow_mem [RING_DEPTH];
    bit                 shadow_written [RING_DEPTH];
    logic [FIELD_W-1:0] shadow_head = '0;
    logic [FIELD_W-1:0] shadow_tail = '0;

    t_ring_status status_q [$];
    int           n_errors      = 0;
    int           send_idle_pct = 28;
    int           recv_idle_pct = 49;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(64'd5_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    // result side back-pressure
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // applies one operation to the shadow ring and returns the status it should report
    function automatic t_ring_status ring_apply(input t_opcode op, input logic [DATA_W-1:0] d,
                                                input logic [FIELD_W-1:0] c,
                                                input logic [FIELD_W-1:0] p);
        t_ring_status       s;
        logic [FIELD_W-1:0] held;
        logic [FIELD_W-1:0] room;
        s    = '0;
        held = shadow_tail - shadow_head;
        room = shadow_head - shadow_tail - 12'd1;
        case (op)
            OP_PUSH: begin
                if (room == '0) begin
                    s.refused = 1'b1;
                end else begin
                    shadow_mem[shadow_tail]     = d;
                    shadow_written[shadow_tail] = 1'b1;
                    shadow_tail                 = shadow_tail + 12'd1;
                end
            end
            OP_DISCARD: begin
                shadow_head = shadow_head + ((c > held) ? held : c);
            end
            OP_READ: begin
                s.read_byte = shadow_mem[p];
            end
            default: ;
        endcase
        s.stored_len = shadow_tail - shadow_head;
        s.free_len   = shadow_head - shadow_tail - 12'd1;
        if (shadow_head <= shadow_tail) begin
            s.contig_free = 12'(RING_DEPTH - int'(shadow_tail) - ((shadow_head == '0) ? 1 : 0));
        end else begin
            s.contig_free = shadow_head - shadow_tail - 12'd1;
        end
        if (shadow_tail < shadow_head) begin
            s.contig_data = 12'(RING_DEPTH - int'(shadow_head));
        end else begin
            s.contig_data = shadow_tail - shadow_head;
        end
        s.head_index = shadow_head;
        s.rear_index = shadow_tail;
        return s;
    endfunction

    function automatic void check_field(input string name, input logic [FIELD_W-1:0] want,
                                        input logic [FIELD_W-1:0] got);
        if (got !== want) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_ring_status want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (status_q.size() == 0) begin
                n_errors++;
                $display("%0t: result with no operation pending, expected none, actual %0h",
                         $time, out_ch.stored_len);
            end else begin
                want = status_q.pop_front();
                check_field("read_byte", FIELD_W'(want.read_byte), FIELD_W'(out_ch.read_byte));
                check_field("refused", FIELD_W'(want.refused), FIELD_W'(out_ch.refused));
                check_field("stored_len", want.stored_len, out_ch.stored_len);
                check_field("free_len", want.free_len, out_ch.free_len);
                check_field("contig_free", want.contig_free, out_ch.contig_free);
                check_field("contig_data", want.contig_data, out_ch.contig_data);
                check_field("head_index", want.head_index, out_ch.head_index);
                check_field("rear_index", want.rear_index, out_ch.rear_index);
            end
        end
    end

    // one operation transfer; called in the time step of a rising edge
    task automatic send_op(input t_opcode op, input logic [DATA_W-1:0] d,
                           input logic [FIELD_W-1:0] c, input logic [FIELD_W-1:0] p);
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= op;
        in_ch.data_byte <= d;
        in_ch.count     <= c;
        in_ch.position  <= p;
        do @(posedge i_clk); while (!in_ch.ready);
        status_q.push_back(ring_apply(op, d, c, p));
    endtask

    // hold the sender off until every pending result has come back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (status_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // empty buffer, clamped discards, byte extremes and reads of fresh entries
    task automatic test_directed_ops();
        send_op(OP_DISCARD, 8'h00, 12'd0, 12'd0);
        send_op(OP_DISCARD, 8'h00, 12'hfff, 12'd0);
        send_op(OP_NOP, 8'hff, 12'hfff, 12'hfff);
        send_op(OP_PUSH, 8'h00, 12'd0, 12'd0);
        send_op(OP_PUSH, 8'hff, 12'd0, 12'd0);
        send_op(OP_PUSH, 8'ha5, 12'd0, 12'd0);
        send_op(OP_PUSH, 8'h5a, 12'd0, 12'd0);
        send_op(OP_READ, 8'h00, 12'd0, 12'd0);
        send_op(OP_READ, 8'h00, 12'd0, 12'd1);
        send_op(OP_READ, 8'h00, 12'd0, 12'd3);
        send_op(OP_DISCARD, 8'h00, 12'd1, 12'd0);
        send_op(OP_READ, 8'h00, 12'd0, 12'd2);
        send_op(OP_DISCARD, 8'h00, 12'hfff, 12'd0);
        send_op(OP_PUSH, 8'h3c, 12'd0, 12'd0);
        send_op(OP_READ, 8'h00, 12'd0, 12'd4);
        send_op(OP_NOP, 8'h00, 12'd0, 12'd0);
    endtask

    // bursts that lean towards filling or draining, with random content
    task automatic test_random_traffic(input int n_ops);
        int                 push_w;
        int                 sel;
        int                 kind;
        t_opcode            op;
        logic [FIELD_W-1:0] held;
        logic [FIELD_W-1:0] cnt;
        logic [FIELD_W-1:0] pos;
        push_w = 30;
        for (int i = 0; i < n_ops; i++) begin
            if (i % 32 == 0) push_w = $urandom_range(10, 60);
            sel = $urandom_range(99);
            if (sel < 4) begin
                op = OP_NOP;
            end else if (sel < 4 + push_w) begin
                op = OP_PUSH;
            end else if (sel < 4 + push_w + (96 - push_w) / 2) begin
                op = OP_READ;
            end else begin
                op = OP_DISCARD;
            end
            held = shadow_tail - shadow_head;
            kind = $urandom_range(9);
            if (kind < 6) begin
                cnt = 12'($urandom_range(6));
            end else if (kind < 8) begin
                cnt = 12'($urandom_range(int'(held) + 2));
            end else begin
                cnt = 12'($urandom_range(4095));
            end
            // only entries that have been written may be read back
            do pos = 12'($urandom_range(4095)); while (!shadow_written[pos]);
            send_op(op, 8'($urandom_range(255)), cnt, pos);
        end
    endtask

    initial begin
        in_ch.valid     <= 1'b0;
        in_ch.opcode    <= OP_NOP;
        in_ch.data_byte <= '0;
        in_ch.count     <= '0;
        in_ch.position  <= '0;
        i_rst_n         <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_ops();
        wait_drained();
        test_random_traffic(PHASE_OPS);
        wait_drained();

        send_idle_pct = 49;
        recv_idle_pct = 28;
        test_random_traffic(PHASE_OPS);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(PHASE_OPS);
        wait_drained();

        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
